FILE: design/sdb_pkg.sv
// ----------------------------------------------------------------------------
// sdb_pkg
// Types, widths and codes shared by the supply/demand balancer modules.
// ----------------------------------------------------------------------------
package sdb_pkg;

    // field widths
    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 4;
    localparam int AMOUNT_W = 20;
    localparam int STATUS_W = 2;

    // fixed point format of the loaded amounts
    localparam int FRAC_BITS = 16;

    // stored integer width
    localparam int STORE_W = 16;
    // counts and totals sized for the largest supported vector (31 entries)
    localparam int CNT_W = 5;
    localparam int VW    = STORE_W + CNT_W;
    localparam int ACC_W = VW + CNT_W;

    localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = '1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_SRC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_DST = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN      = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_SRC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DST   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOTAL = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;

    // input item
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [INDEX_W-1:0]  index;
        logic [AMOUNT_W-1:0] amount;
        logic [STATUS_W-1:0] status;
        logic                last;
    } out_item_t;

    // store write controls
    typedef struct packed {
        logic               src_en;
        logic               dst_en;
        logic               clear;
        logic [STORE_W-1:0] data;
    } sdb_wr_t;

    // store status
    typedef struct packed {
        logic [CNT_W-1:0] src_count;
        logic [CNT_W-1:0] dst_count;
        logic [VW-1:0]    src_total;
        logic [VW-1:0]    dst_total;
        logic             dropped;
    } sdb_stat_t;

    // accumulator controls
    typedef struct packed {
        logic clr;
        logic en;
    } sdb_acc_ctl_t;

    // integer part of a fixed point amount, saturated to the store width
    function automatic logic [STORE_W-1:0] to_int(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] ip;
        ip = v >> FRAC_BITS;
        return (|ip[VALUE_W-1:STORE_W]) ? '1 : ip[STORE_W-1:0];
    endfunction

    // saturate a wide value to the result amount width
    function automatic logic [AMOUNT_W-1:0] sat_amount(input logic [VW-1:0] v);
        return (|v[VW-1:AMOUNT_W]) ? AMOUNT_MAX : v[AMOUNT_W-1:0];
    endfunction

endpackage

FILE: design/sdb_store.sv
// ----------------------------------------------------------------------------
// sdb_store
// Source and destination vectors with their counts, totals and drop flag.
// ----------------------------------------------------------------------------
module sdb_store #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sdb_pkg::sdb_wr_t        wr,
    input  logic [sdb_pkg::CNT_W-1:0] rd_idx,
    output logic [sdb_pkg::STORE_W-1:0] src_rd,
    output logic [sdb_pkg::STORE_W-1:0] dst_rd,
    output sdb_pkg::sdb_stat_t      stat
);
    import sdb_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [STORE_W-1:0] src_mem [MAX_ENTRIES];
    logic [STORE_W-1:0] dst_mem [MAX_ENTRIES];

    logic [CNT_W-1:0] src_count_reg, src_count_next;
    logic [CNT_W-1:0] dst_count_reg, dst_count_next;
    logic [VW-1:0]    src_total_reg, src_total_next;
    logic [VW-1:0]    dst_total_reg, dst_total_next;
    logic             dropped_reg, dropped_next;
    logic [STORE_W-1:0] src_rd_reg;
    logic [STORE_W-1:0] dst_rd_reg;

    logic src_room, dst_room;

    assign src_room = src_count_reg < CNT_W'(MAX_ENTRIES);
    assign dst_room = dst_count_reg < CNT_W'(MAX_ENTRIES);

    // count, total and drop update
    always_comb
    begin
        src_count_next = src_count_reg;
        dst_count_next = dst_count_reg;
        src_total_next = src_total_reg;
        dst_total_next = dst_total_reg;
        dropped_next   = dropped_reg;
        if (wr.clear)
        begin
            src_count_next = '0;
            dst_count_next = '0;
            src_total_next = '0;
            dst_total_next = '0;
            dropped_next   = 1'b0;
        end
        else if (wr.src_en)
        begin
            if (src_room)
            begin
                src_count_next = src_count_reg + CNT_W'(1);
                src_total_next = src_total_reg + VW'(wr.data);
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end
        else if (wr.dst_en)
        begin
            if (dst_room)
            begin
                dst_count_next = dst_count_reg + CNT_W'(1);
                dst_total_next = dst_total_reg + VW'(wr.data);
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_count_reg <= '0;
            dst_count_reg <= '0;
            src_total_reg <= '0;
            dst_total_reg <= '0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            src_count_reg <= src_count_next;
            dst_count_reg <= dst_count_next;
            src_total_reg <= src_total_next;
            dst_total_reg <= dst_total_next;
            dropped_reg   <= dropped_next;
        end
    end

    // vector writes at the fill position
    always_ff @(posedge clk)
    begin
        if (wr.src_en && !wr.clear && src_room)
        begin
            src_mem[src_count_reg[IDX_W-1:0]] <= wr.data;
        end
        if (wr.dst_en && !wr.clear && dst_room)
        begin
            dst_mem[dst_count_reg[IDX_W-1:0]] <= wr.data;
        end
    end

    // registered read, one position shared by both vectors
    always_ff @(posedge clk)
    begin
        src_rd_reg <= src_mem[rd_idx[IDX_W-1:0]];
        dst_rd_reg <= dst_mem[rd_idx[IDX_W-1:0]];
    end

    assign src_rd = src_rd_reg;
    assign dst_rd = dst_rd_reg;

    assign stat.src_count = src_count_reg;
    assign stat.dst_count = dst_count_reg;
    assign stat.src_total = src_total_reg;
    assign stat.dst_total = dst_total_reg;
    assign stat.dropped   = dropped_reg;

endmodule

FILE: design/sdb_level_unit.sv
// ----------------------------------------------------------------------------
// sdb_level_unit
// Shared subtract and accumulate unit: sums the shortfall of entries below a
// candidate level, one entry per cycle while enabled.
// ----------------------------------------------------------------------------
module sdb_level_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sdb_pkg::sdb_acc_ctl_t    ctl,
    input  logic [sdb_pkg::VW-1:0]   cand,
    input  logic [sdb_pkg::VW-1:0]   entry,
    output logic [sdb_pkg::ACC_W-1:0] acc
);
    import sdb_pkg::*;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [VW-1:0]    gap;

    // shortfall of this entry below the candidate level
    assign gap = (cand > entry) ? (cand - entry) : '0;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clr)
        begin
            acc_next = '0;
        end
        else if (ctl.en)
        begin
            acc_next = acc_reg + ACC_W'(gap);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

FILE: design/supply_demand_balancer.sv
// ----------------------------------------------------------------------------
// supply_demand_balancer
// Loads source and destination integer vectors, levels the destination to
// the source total and emits sources, adjusted destinations and the total.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  item      in         start && !busy       item   (cmd, value)
//  result    out        strobe, one cycle    result (kind, index, amount,
//                                                    status, last)
//
//  load items are accepted one per cycle; busy stays low
//  a run levels the destination by a search over 21 level bits, then emits
//  sources, destinations and the total; the shared level unit adds one
//  destination entry per cycle for each search bit
//  with an empty destination a run skips the search and the residual pass
//  reset clears counts, totals and the drop flag; results cannot be stalled
//
module supply_demand_balancer #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  sdb_pkg::in_item_t   item,
    output logic                strobe,
    output sdb_pkg::out_item_t  result
);
    import sdb_pkg::*;

    localparam int BIT_W = $clog2(VW);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SEARCH   = 3'd1;
    localparam logic [2:0] ST_RESID    = 3'd2;
    localparam logic [2:0] ST_EMIT_SRC = 3'd3;
    localparam logic [2:0] ST_EMIT_DST = 3'd4;
    localparam logic [2:0] ST_EMIT_TOT = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [VW-1:0]       t_reg, t_next;
    logic [VW-1:0]       d_reg, d_next;
    logic                inv_reg, inv_next;
    logic [CNT_W-1:0]    r_reg, r_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                strobe_reg, strobe_next;
    out_item_t           result_reg, result_next;

    sdb_wr_t             wr;
    sdb_stat_t           stat;
    sdb_acc_ctl_t        acc_ctl;
    logic [STORE_W-1:0]  src_rd, dst_rd;
    logic [ACC_W-1:0]    acc;
    logic [VW-1:0]       cand, dst_ext, entry, new_val, out_val;
    logic [ACC_W-1:0]    resid;
    logic                scan_live, scanning;

    // store reads are registered, so the read position is driven from idx_next
    sdb_store #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .rd_idx (idx_next),
        .src_rd (src_rd),
        .dst_rd (dst_rd),
        .stat   (stat)
    );

    sdb_level_unit u_level (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (acc_ctl),
        .cand  (cand),
        .entry (entry),
        .acc   (acc)
    );

    // lowering works on complemented entries, so both cases are a raise
    assign dst_ext   = VW'(dst_rd);
    assign entry     = inv_reg ? ~dst_ext : dst_ext;
    assign cand      = (state_reg == ST_SEARCH) ? (t_reg | (VW'(1) << bit_reg)) : t_reg;
    assign scan_live = idx_reg < stat.dst_count;
    assign scanning  = (state_reg == ST_SEARCH) || (state_reg == ST_RESID);
    assign resid     = ACC_W'(d_reg) - acc;

    // adjusted destination entry
    always_comb
    begin
        if (entry <= t_reg)
        begin
            new_val = t_reg + ((r_reg != '0) ? VW'(1) : VW'(0));
        end
        else
        begin
            new_val = entry;
        end
        out_val = inv_reg ? ~new_val : new_val;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        bit_next    = bit_reg;
        t_next      = t_reg;
        d_next      = d_reg;
        inv_next    = inv_reg;
        r_next      = r_reg;
        status_next = status_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        wr.src_en   = 1'b0;
        wr.dst_en   = 1'b0;
        wr.clear    = 1'b0;
        wr.data     = to_int(item.value);
        acc_ctl.en  = scanning && scan_live;
        acc_ctl.clr = scanning && !scan_live;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (item.cmd)
                        CMD_LOAD_SRC: wr.src_en = 1'b1;
                        CMD_LOAD_DST: wr.dst_en = 1'b1;
                        CMD_RUN:
                        begin
                            inv_next = stat.dst_total > stat.src_total;
                            d_next   = (stat.dst_total > stat.src_total)
                                     ? (stat.dst_total - stat.src_total)
                                     : (stat.src_total - stat.dst_total);
                            if (stat.dst_count == '0 && stat.src_total != '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else if (stat.dropped)
                            begin
                                status_next = STATUS_DROPPED;
                            end
                            else
                            begin
                                status_next = STATUS_OK;
                            end
                            idx_next   = '0;
                            bit_next   = BIT_W'(VW - 1);
                            t_next     = '0;
                            state_next = (stat.dst_count == '0) ? ST_EMIT_SRC : ST_SEARCH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // one level bit per pass over the destination
            ST_SEARCH:
            begin
                if (scan_live)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                else
                begin
                    if (acc <= ACC_W'(d_reg))
                    begin
                        t_next = cand;
                    end
                    idx_next = '0;
                    if (bit_reg == '0)
                    begin
                        state_next = ST_RESID;
                    end
                    else
                    begin
                        bit_next = bit_reg - BIT_W'(1);
                    end
                end
            end

            // units left over after filling up to the final level
            ST_RESID:
            begin
                if (scan_live)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                else
                begin
                    r_next     = resid[CNT_W-1:0];
                    idx_next   = '0;
                    state_next = ST_EMIT_SRC;
                end
            end

            ST_EMIT_SRC:
            begin
                if (idx_reg < stat.src_count)
                begin
                    strobe_next        = 1'b1;
                    result_next.kind   = KIND_SRC;
                    result_next.index  = idx_reg[INDEX_W-1:0];
                    result_next.amount = AMOUNT_W'(src_rd);
                    result_next.status = status_reg;
                    result_next.last   = 1'b0;
                    idx_next           = idx_reg + CNT_W'(1);
                end
                else
                begin
                    idx_next   = '0;
                    state_next = (stat.dst_count != '0) ? ST_EMIT_DST : ST_EMIT_TOT;
                end
            end

            ST_EMIT_DST:
            begin
                if (scan_live)
                begin
                    strobe_next        = 1'b1;
                    result_next.kind   = KIND_DST;
                    result_next.index  = idx_reg[INDEX_W-1:0];
                    result_next.amount = sat_amount(out_val);
                    result_next.status = status_reg;
                    result_next.last   = 1'b0;
                    idx_next           = idx_reg + CNT_W'(1);
                    if (entry <= t_reg && r_reg != '0)
                    begin
                        r_next = r_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    state_next = ST_EMIT_TOT;
                end
            end

            ST_EMIT_TOT:
            begin
                strobe_next        = 1'b1;
                result_next.kind   = KIND_TOTAL;
                result_next.index  = '0;
                result_next.amount = sat_amount(stat.src_total);
                result_next.status = status_reg;
                result_next.last   = 1'b1;
                wr.clear           = 1'b1;
                state_next         = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            bit_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            bit_reg    <= bit_next;
            strobe_reg <= strobe_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        d_reg      <= d_next;
        inv_reg    <= inv_next;
        r_reg      <= r_next;
        status_reg <= status_next;
        result_reg <= result_next;
    end

    assign busy   = state_reg != ST_IDLE;
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for supply_demand_balancer. Source and destination
// vectors are loaded as fixed-point amounts and followed by a run command.
// A scoreboard keeps its own copy of the stores, levels the destination
// vector to the source total and checks every emitted result in order.
// A few directed runs come first, then random load/run batches that
// include overfull vectors, empty vectors and unused commands.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sdb_pkg::*;

    localparam int  ENTRIES     = 16;
    localparam int  ITEM_GOAL   = 350;
    localparam int  IDLE_LIMIT  = 4000;
    localparam int  DRAIN_WAIT  = 40;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // scoreboard: mirrors the stores and predicts each run's results
    class balance_scoreboard;
        logic [STORE_W-1:0] src_vals [ENTRIES];
        logic [STORE_W-1:0] dst_vals [ENTRIES];
        int unsigned        levels   [ENTRIES];
        int unsigned        src_n;
        int unsigned        dst_n;
        int unsigned        src_sum;
        int unsigned        dst_sum;
        bit                 dropped;
        out_item_t          expected_q [$];
        int                 errors;
        int                 checked;
        int                 runs;
        int                 dropped_runs;
        int                 empty_runs;

        function new();
            errors       = 0;
            checked      = 0;
            runs         = 0;
            dropped_runs = 0;
            empty_runs   = 0;
            clear_vectors();
        endfunction

        function void clear_vectors();
            src_n   = 0;
            dst_n   = 0;
            src_sum = 0;
            dst_sum = 0;
            dropped = 1'b0;
        endfunction

        // take units from the first highest entries until d are gone
        function void trim_peaks(int unsigned n, int unsigned d);
            int unsigned top;
            int unsigned next;
            int unsigned cnt;
            int unsigned step;
            int unsigned q;
            int unsigned r;
            bit          has_next;
            while (d != 0)
            begin
                top = 0;
                for (int i = 0; i < n; i++)
                    if (levels[i] > top) top = levels[i];
                cnt      = 0;
                next     = 0;
                has_next = 1'b0;
                for (int i = 0; i < n; i++)
                begin
                    if (levels[i] == top)
                        cnt++;
                    else if (!has_next || levels[i] > next)
                    begin
                        next     = levels[i];
                        has_next = 1'b1;
                    end
                end
                step = has_next ? top - next : top;
                if (step > 0 && cnt * step <= d)
                begin
                    for (int i = 0; i < n; i++)
                        if (levels[i] == top) levels[i] -= step;
                    d -= cnt * step;
                end
                else
                begin
                    q = d / cnt;
                    r = d % cnt;
                    for (int i = 0; i < n; i++)
                    begin
                        if (levels[i] == top)
                        begin
                            levels[i] -= q;
                            if (r != 0)
                            begin
                                levels[i] -= 1;
                                r--;
                            end
                        end
                    end
                    d = 0;
                end
            end
        endfunction

        // add units to the first lowest entries until d are placed
        function void fill_valleys(int unsigned n, int unsigned d);
            int unsigned bottom;
            int unsigned next;
            int unsigned cnt;
            int unsigned q;
            int unsigned r;
            bit          has_next;
            while (d != 0)
            begin
                bottom = levels[0];
                for (int i = 0; i < n; i++)
                    if (levels[i] < bottom) bottom = levels[i];
                cnt      = 0;
                next     = 0;
                has_next = 1'b0;
                for (int i = 0; i < n; i++)
                begin
                    if (levels[i] == bottom)
                        cnt++;
                    else if (!has_next || levels[i] < next)
                    begin
                        next     = levels[i];
                        has_next = 1'b1;
                    end
                end
                if (has_next && cnt * (next - bottom) <= d)
                begin
                    for (int i = 0; i < n; i++)
                        if (levels[i] == bottom) levels[i] += next - bottom;
                    d -= cnt * (next - bottom);
                end
                else
                begin
                    q = d / cnt;
                    r = d % cnt;
                    for (int i = 0; i < n; i++)
                    begin
                        if (levels[i] == bottom)
                        begin
                            levels[i] += q;
                            if (r != 0)
                            begin
                                levels[i] += 1;
                                r--;
                            end
                        end
                    end
                    d = 0;
                end
            end
        endfunction

        function void push_result(logic [KIND_W-1:0] kind, int unsigned idx,
                                  int unsigned amt, logic [STATUS_W-1:0] status,
                                  logic last);
            out_item_t r;
            r.kind   = kind;
            r.index  = idx[INDEX_W-1:0];
            r.amount = (amt > AMOUNT_MAX) ? AMOUNT_MAX : amt[AMOUNT_W-1:0];
            r.status = status;
            r.last   = last;
            expected_q.push_back(r);
        endfunction

        // level the destination vector and queue the run's results
        function void predict_run();
            logic [STATUS_W-1:0] status;
            status = dropped ? STATUS_DROPPED : STATUS_OK;
            for (int i = 0; i < dst_n; i++)
                levels[i] = dst_vals[i];
            if (dst_n == 0)
            begin
                if (src_sum != 0) status = STATUS_EMPTY;
            end
            else if (dst_sum > src_sum)
                trim_peaks(dst_n, dst_sum - src_sum);
            else if (dst_sum < src_sum)
                fill_valleys(dst_n, src_sum - dst_sum);

            for (int i = 0; i < src_n; i++)
                push_result(KIND_SRC, i, src_vals[i], status, 1'b0);
            if (dst_n != 0)
                for (int i = 0; i < dst_n; i++)
                    push_result(KIND_DST, i, levels[i], status, 1'b0);
            push_result(KIND_TOTAL, 0, src_sum, status, 1'b1);

            runs++;
            if (status == STATUS_DROPPED) dropped_runs++;
            if (status == STATUS_EMPTY) empty_runs++;
            clear_vectors();
        endfunction

        // accepted input item
        function void note_item(in_item_t it);
            logic [VALUE_W-1:0] ipart;
            logic [STORE_W-1:0] whole;
            ipart = it.value >> FRAC_BITS;
            whole = (ipart > 32'h0000_FFFF) ? 16'hFFFF : ipart[STORE_W-1:0];
            case (it.cmd)
                CMD_LOAD_SRC:
                begin
                    if (src_n < ENTRIES)
                    begin
                        src_vals[src_n] = whole;
                        src_n++;
                        src_sum += whole;
                    end
                    else
                        dropped = 1'b1;
                end
                CMD_LOAD_DST:
                begin
                    if (dst_n < ENTRIES)
                    begin
                        dst_vals[dst_n] = whole;
                        dst_n++;
                        dst_sum += whole;
                    end
                    else
                        dropped = 1'b1;
                end
                CMD_RUN:
                    predict_run();
                default: ;
            endcase
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
            if (exp_v != got_v)
            begin
                $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        // accepted result against the oldest expectation
        function void check_result(out_item_t got);
            out_item_t exp_r;
            if (expected_q.size() == 0)
            begin
                $error("result with nothing expected: kind %0d index %0d amount %0d",
                       got.kind, got.index, got.amount);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            checked++;
            compare_field("kind",   exp_r.kind,   got.kind);
            compare_field("index",  exp_r.index,  got.index);
            compare_field("amount", exp_r.amount, got.amount);
            compare_field("status", exp_r.status, got.status);
            compare_field("last",   exp_r.last,   got.last);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    in_item_t   item;
    logic       strobe;
    out_item_t  result;

    balance_scoreboard sb;
    int          idle_cycles;
    int          burst_left;
    int          load_items;
    int          noise_items;

    supply_demand_balancer #(
        .MAX_ENTRIES(ENTRIES)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // result monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check_result(result);
        if (strobe || (start && !busy))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no activity for %0d cycles, %0d results pending",
                     IDLE_LIMIT, sb.expected_q.size());
            $display("supply_demand_balancer: mismatch");
            $finish;
        end
    end

    // drive one item in bursts with random gaps; returns at a falling edge
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value);
        in_item_t it;
        int       gap;
        it.cmd   = cmd;
        it.value = value;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        start <= 1'b1;
        item  <= it;
        forever
        begin
            @(posedge clk);
            if (!busy) break;
        end
        sb.note_item(it);
        if (cmd == CMD_UNUSED)
            noise_items++;
        else if (cmd != CMD_RUN)
            load_items++;
        @(negedge clk);
    endtask

    // random amount with a mix of small, huge and edge values
    function automatic logic [VALUE_W-1:0] rand_amount();
        case ($urandom_range(0, 6))
            0:       return $urandom;
            1:       return {16'($urandom_range(0, 20)), 16'($urandom)};
            2:       return 32'hFFFF_FFFF;
            3:       return {16'h0000, 16'($urandom)};
            4:       return {16'($urandom_range(0, 1000)), 16'($urandom)};
            5:       return {16'($urandom_range(60000, 65535)), 16'($urandom)};
            default: return {16'($urandom_range(0, 5)), 16'h0000};
        endcase
    endfunction

    // vector length: mostly within capacity, sometimes empty or overfull
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return $urandom_range(17, 19);
        if (r <= 3) return $urandom_range(1, 3);
        return $urandom_range(1, 16);
    endfunction

    initial
    begin
        int n_src;
        int n_dst;
        sb          = new();
        idle_cycles = 0;
        burst_left  = 0;
        load_items  = 0;
        noise_items = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty run, unused command
        send_item(CMD_RUN, 32'h0);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF);
        // all-ones, zero and fraction-only amounts; destination raised
        send_item(CMD_LOAD_SRC, 32'hFFFF_FFFF);
        send_item(CMD_LOAD_SRC, 32'h0000_0000);
        send_item(CMD_LOAD_SRC, 32'h0001_0000);
        send_item(CMD_LOAD_DST, 32'h0000_FFFF);
        send_item(CMD_LOAD_DST, 32'h7FFF_8000);
        send_item(CMD_RUN, 32'hFFFF_FFFF);
        // destination above source total, lowered
        send_item(CMD_LOAD_SRC, 32'h0003_0000);
        send_item(CMD_LOAD_DST, 32'h0005_0000);
        send_item(CMD_LOAD_DST, 32'h0005_0000);
        send_item(CMD_LOAD_DST, 32'h0002_0000);
        send_item(CMD_RUN, 32'h0);
        // empty destination with nonzero source total
        send_item(CMD_LOAD_SRC, 32'h0001_0000);
        send_item(CMD_RUN, 32'h0);
        // totals already equal
        send_item(CMD_LOAD_SRC, 32'h0004_8000);
        send_item(CMD_LOAD_DST, 32'h0004_0000);
        send_item(CMD_RUN, 32'h0);
        // destination only, source total zero
        send_item(CMD_LOAD_DST, 32'h0009_0000);
        send_item(CMD_RUN, 32'h0);

        // random load batches, each closed by a run
        while (load_items + sb.runs < ITEM_GOAL)
        begin
            n_src = pick_length();
            n_dst = pick_length();
            while (n_src > 0 || n_dst > 0)
            begin
                if ($urandom_range(0, 24) == 0)
                    send_item(CMD_UNUSED, $urandom);
                if (n_src > 0 && (n_dst == 0 || $urandom_range(0, 1) == 1))
                begin
                    send_item(CMD_LOAD_SRC, rand_amount());
                    n_src--;
                end
                else
                begin
                    send_item(CMD_LOAD_DST, rand_amount());
                    n_dst--;
                end
            end
            send_item(CMD_RUN, $urandom);
        end
        start <= 1'b0;

        // drain
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d runs from %0d loads and %0d unused commands",
                 sb.runs, load_items, noise_items);
        $display("%0d results checked, %0d runs with dropped entries, %0d with empty destination",
                 sb.checked, sb.dropped_runs, sb.empty_runs);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("supply_demand_balancer: match");
        else
            $display("supply_demand_balancer: mismatch");
        $finish;
    end

endmodule
